>>> sv/aorb_pkg.sv
package aorb_pkg;

   localparam int DefRingDepth = 10;
   localparam int DefMaxBatch  = 16;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_POP    = 1'b1;

   typedef struct packed {
      logic        operation;
      logic signed [15:0] temperature;
      logic [15:0] humidity;
      logic [15:0] light;
      logic [15:0] tank_level;
      logic        pump_on;
      logic        lights_on;
      logic        irrigated;
      logic [31:0] sample_time;
      logic        last_in_batch;
   } req_type;

   typedef struct packed {
      logic [31:0] oldest_time;
      logic signed [15:0] oldest_temperature;
      logic [15:0] oldest_humidity;
      logic [15:0] oldest_light;
      logic [15:0] oldest_tank;
      logic        oldest_pump;
      logic        oldest_lights;
      logic        oldest_irrigated;
      logic        oldest_present;
      logic [3:0]  entry_count;
      logic        ring_full;
      logic        stored_now;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_STORE,
      ST_READ,
      ST_LOAD,
      ST_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic div_start;
      logic div_step;
      logic store;
      logic read;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_pop;
      logic closes_batch;
      logic div_done;
   } sts_type;

endpackage

>>> sv/aorb_datapath.sv
module aorb_datapath
   import aorb_pkg::*;
#(
   parameter int RING_DEPTH = DefRingDepth,
   parameter int MAX_BATCH  = DefMaxBatch
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_data
);

   localparam int PW  = $clog2(RING_DEPTH);
   localparam int CW  = $clog2(RING_DEPTH + 1);
   localparam int NW  = $clog2(MAX_BATCH + 1);
   localparam int SW  = 16 + NW;
   localparam int QB  = SW;
   localparam int QCW = $clog2(QB + 1);

   req_type item_ff;
   logic [PW-1:0] wp_ff, wp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [SW:0] tsum_ff, tsum_in;
   logic [SW-1:0] hsum_ff, hsum_in, lsum_ff, lsum_in;
   logic [NW-1:0] bn_ff, bn_in;
   logic stored_ff, stored_in;

   // Divider state: three restoring dividers sharing one step counter.
   logic [SW-1:0] tq_ff, hq_ff, lq_ff;
   logic [NW:0] tr_ff, hr_ff, lr_ff;
   logic tneg_ff;
   logic [QCW-1:0] dcnt_ff;

   logic [31:0] m_time [RING_DEPTH];
   logic [15:0] m_temp [RING_DEPTH];
   logic [15:0] m_hum [RING_DEPTH];
   logic [15:0] m_light [RING_DEPTH];
   logic [15:0] m_tank [RING_DEPTH];
   logic [2:0]  m_flags [RING_DEPTH];

   logic [31:0] rd_time;
   logic [15:0] rd_temp, rd_hum, rd_light, rd_tank;
   logic [2:0]  rd_flags;
   logic [PW-1:0] rd_idx;
   logic [PW:0]  rd_sum;
   rsp_type rsp_ff;

   assign sts.is_pop       = (item_ff.operation == OP_POP);
   assign sts.closes_batch = item_ff.last_in_batch;
   assign sts.div_done     = (dcnt_ff == '0);
   assign rsp_data         = rsp_ff;

   // Capture the accepted beat.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_ff <= req_data;
      end
   end

   // Accumulate, store and pop.
   always_comb begin
      tsum_in   = tsum_ff;
      hsum_in   = hsum_ff;
      lsum_in   = lsum_ff;
      bn_in     = bn_ff;
      wp_in     = wp_ff;
      cnt_in    = cnt_ff;
      stored_in = stored_ff;
      if (cmd.accept) begin
         stored_in = 1'b0;
         if (req_data.operation == OP_POP) begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end
         end else if (bn_ff < NW'(MAX_BATCH)) begin
            tsum_in = tsum_ff + (SW+1)'(req_data.temperature);
            hsum_in = hsum_ff + SW'(req_data.humidity);
            lsum_in = lsum_ff + SW'(req_data.light);
            bn_in   = bn_ff + 1'b1;
         end
      end
      if (cmd.store) begin
         wp_in     = (wp_ff == PW'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         cnt_in    = (cnt_ff == CW'(RING_DEPTH)) ? cnt_ff : cnt_ff + 1'b1;
         tsum_in   = '0;
         hsum_in   = '0;
         lsum_in   = '0;
         bn_in     = '0;
         stored_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tsum_ff   <= '0;
         hsum_ff   <= '0;
         lsum_ff   <= '0;
         bn_ff     <= '0;
         wp_ff     <= '0;
         cnt_ff    <= '0;
         stored_ff <= 1'b0;
      end else begin
         tsum_ff   <= tsum_in;
         hsum_ff   <= hsum_in;
         lsum_ff   <= lsum_in;
         bn_ff     <= bn_in;
         wp_ff     <= wp_in;
         cnt_ff    <= cnt_in;
         stored_ff <= stored_in;
      end
   end

   // One quotient bit per step for each of the three sums.
   logic [NW:0] tr_sh, hr_sh, lr_sh;
   logic [SW-1:0] tmag;
   assign tmag  = tsum_ff[SW] ? SW'(-tsum_ff) : SW'(tsum_ff);
   assign tr_sh = {tr_ff[NW-1:0], tq_ff[SW-1]};
   assign hr_sh = {hr_ff[NW-1:0], hq_ff[SW-1]};
   assign lr_sh = {lr_ff[NW-1:0], lq_ff[SW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_start) begin
         dcnt_ff <= QCW'(QB);
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         tq_ff   <= tmag;
         hq_ff   <= hsum_ff;
         lq_ff   <= lsum_ff;
         tr_ff   <= '0;
         hr_ff   <= '0;
         lr_ff   <= '0;
         tneg_ff <= tsum_ff[SW];
      end else if (cmd.div_step) begin
         if (tr_sh >= {1'b0, bn_ff}) begin
            tr_ff <= tr_sh - {1'b0, bn_ff};
            tq_ff <= {tq_ff[SW-2:0], 1'b1};
         end else begin
            tr_ff <= tr_sh;
            tq_ff <= {tq_ff[SW-2:0], 1'b0};
         end
         if (hr_sh >= {1'b0, bn_ff}) begin
            hr_ff <= hr_sh - {1'b0, bn_ff};
            hq_ff <= {hq_ff[SW-2:0], 1'b1};
         end else begin
            hr_ff <= hr_sh;
            hq_ff <= {hq_ff[SW-2:0], 1'b0};
         end
         if (lr_sh >= {1'b0, bn_ff}) begin
            lr_ff <= lr_sh - {1'b0, bn_ff};
            lq_ff <= {lq_ff[SW-2:0], 1'b1};
         end else begin
            lr_ff <= lr_sh;
            lq_ff <= {lq_ff[SW-2:0], 1'b0};
         end
      end
   end

   // Ring memory write.
   logic [SW-1:0] tq_signed;
   assign tq_signed = tneg_ff ? -tq_ff : tq_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         m_time[wp_ff]  <= item_ff.sample_time;
         m_temp[wp_ff]  <= tq_signed[15:0];
         m_hum[wp_ff]   <= hq_ff[15:0];
         m_light[wp_ff] <= lq_ff[15:0];
         m_tank[wp_ff]  <= item_ff.tank_level;
         m_flags[wp_ff] <= {item_ff.irrigated, item_ff.lights_on, item_ff.pump_on};
      end
   end

   // Oldest entry sits cnt_ff places behind the write pointer.
   assign rd_sum = {1'b0, wp_ff} + (PW+1)'(RING_DEPTH) - (PW+1)'(cnt_ff);
   assign rd_idx = (rd_sum >= (PW+1)'(RING_DEPTH)) ? PW'(rd_sum - (PW+1)'(RING_DEPTH))
                                                   : PW'(rd_sum);

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_time  <= m_time[rd_idx];
         rd_temp  <= m_temp[rd_idx];
         rd_hum   <= m_hum[rd_idx];
         rd_light <= m_light[rd_idx];
         rd_tank  <= m_tank[rd_idx];
         rd_flags <= m_flags[rd_idx];
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (cnt_ff != '0) begin
            rsp_ff.oldest_time        <= rd_time;
            rsp_ff.oldest_temperature <= rd_temp;
            rsp_ff.oldest_humidity    <= rd_hum;
            rsp_ff.oldest_light       <= rd_light;
            rsp_ff.oldest_tank        <= rd_tank;
            rsp_ff.oldest_pump        <= rd_flags[0];
            rsp_ff.oldest_lights      <= rd_flags[1];
            rsp_ff.oldest_irrigated   <= rd_flags[2];
            rsp_ff.oldest_present     <= 1'b1;
         end else begin
            rsp_ff.oldest_time        <= '0;
            rsp_ff.oldest_temperature <= '0;
            rsp_ff.oldest_humidity    <= '0;
            rsp_ff.oldest_light       <= '0;
            rsp_ff.oldest_tank        <= '0;
            rsp_ff.oldest_pump        <= 1'b0;
            rsp_ff.oldest_lights      <= 1'b0;
            rsp_ff.oldest_irrigated   <= 1'b0;
            rsp_ff.oldest_present     <= 1'b0;
         end
         rsp_ff.entry_count <= 4'(cnt_ff);
         rsp_ff.ring_full   <= (cnt_ff == CW'(RING_DEPTH));
         rsp_ff.stored_now  <= stored_ff;
      end
   end

endmodule

>>> sv/aorb_control.sv
module aorb_control
   import aorb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.is_pop || !sts.closes_batch) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            if (sts.div_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs. ST_DIV starts the divider; ST_STORE steps it, then writes.
   // ST_READ registers the oldest entry, and ST_LOAD moves it into the result.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_DIV: cmd.div_start = 1'b1;
         ST_STORE: begin
            cmd.div_step = !sts.div_done;
            cmd.store    = sts.div_done;
         end
         ST_READ: begin
            cmd.read = 1'b1;
         end
         ST_LOAD: begin
            cmd.load_rsp = 1'b1;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

>>> sv/averaging_overwrite_ring_buffer.sv
// A sample or pop passes from accept through ST_DIV, ST_READ and ST_LOAD to the
// result in ST_OUT; a batch-closing sample also steps the bit-serial divider in ST_STORE.
// Items are handled one at a time; the next beat is accepted after the result is taken.
// Reset (synchronous, active high) empties the ring and clears the open batch.
module averaging_overwrite_ring_buffer
   import aorb_pkg::*;
#(
   parameter int RING_DEPTH = DefRingDepth,
   parameter int MAX_BATCH  = DefMaxBatch
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;
   logic    rsp_valid_int;

   aorb_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid_int),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   aorb_datapath #(
      .RING_DEPTH (RING_DEPTH),
      .MAX_BATCH  (MAX_BATCH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   assign rsp_valid = rsp_valid_int;

endmodule

>>> test/ring_checker.sv
`timescale 1ns / 100ps

module ring_checker
   import aorb_pkg::*;
#(
   parameter int RING_DEPTH = DefRingDepth,
   parameter int MAX_BATCH  = DefMaxBatch
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count,
   output int      stored_count
);

   // Shadow copy of the ring and the open batch.
   logic [31:0] shadow_time [RING_DEPTH];
   logic [15:0] shadow_temp [RING_DEPTH];
   logic [15:0] shadow_hum [RING_DEPTH];
   logic [15:0] shadow_light [RING_DEPTH];
   logic [15:0] shadow_tank [RING_DEPTH];
   logic [2:0]  shadow_flags [RING_DEPTH];
   int          wr_ptr;
   int          fill;
   longint      temp_acc;
   longint      hum_acc;
   longint      light_acc;
   int          batch_len;
   rsp_type     expected_beats [$];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Apply one accepted beat to the shadow state and return the expected response.
   function automatic rsp_type predict_oldest(input req_type r);
      rsp_type p;
      int      idx;
      longint  n;
      p = '0;
      if (r.operation == OP_POP) begin
         if (fill > 0) fill--;
      end else begin
         if (batch_len < MAX_BATCH) begin
            temp_acc += longint'(r.temperature);
            hum_acc += longint'(r.humidity);
            light_acc += longint'(r.light);
            batch_len++;
         end
         if (r.last_in_batch) begin
            n = batch_len;
            idx = wr_ptr;
            shadow_time[idx] = r.sample_time;
            shadow_temp[idx] = 16'(temp_acc / n);
            shadow_hum[idx] = 16'(hum_acc / n);
            shadow_light[idx] = 16'(light_acc / n);
            shadow_tank[idx] = r.tank_level;
            shadow_flags[idx] = {r.irrigated, r.lights_on, r.pump_on};
            wr_ptr = (idx + 1) % RING_DEPTH;
            if (fill < RING_DEPTH) fill++;
            temp_acc = 0;
            hum_acc = 0;
            light_acc = 0;
            batch_len = 0;
            p.stored_now = 1'b1;
         end
      end
      if (fill > 0) begin
         idx = (wr_ptr + RING_DEPTH - fill) % RING_DEPTH;
         p.oldest_time = shadow_time[idx];
         p.oldest_temperature = shadow_temp[idx];
         p.oldest_humidity = shadow_hum[idx];
         p.oldest_light = shadow_light[idx];
         p.oldest_tank = shadow_tank[idx];
         {p.oldest_irrigated, p.oldest_lights, p.oldest_pump} = shadow_flags[idx];
         p.oldest_present = 1'b1;
      end
      p.entry_count = 4'(fill);
      p.ring_full = (fill >= RING_DEPTH);
      return p;
   endfunction

   // Sample both channels at the edge; predictions are made on input beats.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         wr_ptr <= 0;
         fill <= 0;
         temp_acc <= 0;
         hum_acc <= 0;
         light_acc <= 0;
         batch_len <= 0;
         error_count <= 0;
         stored_count <= 0;
         expected_beats.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat", longint'(rsp_data.entry_count), 0);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_data.oldest_time !== want.oldest_time)
                  report_mismatch("oldest_time", rsp_data.oldest_time, want.oldest_time);
               if (rsp_data.oldest_temperature !== want.oldest_temperature)
                  report_mismatch("oldest_temperature", rsp_data.oldest_temperature,
                                  want.oldest_temperature);
               if (rsp_data.oldest_humidity !== want.oldest_humidity)
                  report_mismatch("oldest_humidity", rsp_data.oldest_humidity,
                                  want.oldest_humidity);
               if (rsp_data.oldest_light !== want.oldest_light)
                  report_mismatch("oldest_light", rsp_data.oldest_light, want.oldest_light);
               if (rsp_data.oldest_tank !== want.oldest_tank)
                  report_mismatch("oldest_tank", rsp_data.oldest_tank, want.oldest_tank);
               if (rsp_data.oldest_pump !== want.oldest_pump)
                  report_mismatch("oldest_pump", rsp_data.oldest_pump, want.oldest_pump);
               if (rsp_data.oldest_lights !== want.oldest_lights)
                  report_mismatch("oldest_lights", rsp_data.oldest_lights, want.oldest_lights);
               if (rsp_data.oldest_irrigated !== want.oldest_irrigated)
                  report_mismatch("oldest_irrigated", rsp_data.oldest_irrigated,
                                  want.oldest_irrigated);
               if (rsp_data.oldest_present !== want.oldest_present)
                  report_mismatch("oldest_present", rsp_data.oldest_present,
                                  want.oldest_present);
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp_data.entry_count, want.entry_count);
               if (rsp_data.ring_full !== want.ring_full)
                  report_mismatch("ring_full", rsp_data.ring_full, want.ring_full);
               if (rsp_data.stored_now !== want.stored_now)
                  report_mismatch("stored_now", rsp_data.stored_now, want.stored_now);
               if (want.stored_now) stored_count <= stored_count + 1;
            end
         end
         if (req_valid && !req_stall) begin
            expected_beats.push_back(predict_oldest(req_data));
         end
      end
   end

   assign pending_count = expected_beats.size();

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import aorb_pkg::*;

   localparam int WatchdogLimit = 20000;
   localparam int RandomItems   = 1700;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      error_count;
   int      pending_count;
   int      stored_count;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      hold_off;
   int      quiet_cycles;
   int      sent_count;

   averaging_overwrite_ring_buffer u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   ring_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count),
      .stored_count(stored_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_off = 0;
   end

   // Receiver: random stall, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog expired with %0d beats outstanding", pending_count);
            $display("averaging_overwrite_ring_buffer regression: fail");
            $finish;
         end
      end
   end

   // Offer one beat, after an optional idle gap, and wait until it is taken.
   // Valid stays high after a beat is taken unless an idle gap follows.
   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   function automatic req_type random_sample(input logic closing);
      req_type r;
      r = req_type'(117'({$urandom, $urandom, $urandom, $urandom}));
      r.operation = OP_SAMPLE;
      r.last_in_batch = closing;
      return r;
   endfunction

   function automatic req_type pop_beat();
      req_type r;
      r = req_type'(117'({$urandom, $urandom, $urandom, $urandom}));
      r.operation = OP_POP;
      return r;
   endfunction

   function automatic req_type extreme_sample(input logic high, input logic closing);
      req_type r;
      r = high ? '1 : '0;
      r.temperature = high ? 16'sh7fff : 16'sh8000;
      r.operation = OP_SAMPLE;
      r.last_in_batch = closing;
      return r;
   endfunction

   // Random batches: mostly short, a few past the batch limit, with pops mixed in.
   task automatic random_phase(input int items);
      int len;
      int done;
      done = 0;
      while (done < items) begin
         if ($urandom_range(99) < 25) begin
            send_beat(pop_beat());
            done++;
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 5);
            for (int i = 1; i <= len; i++) begin
               send_beat(random_sample(i == len));
            end
            done += len;
         end
      end
   endtask

   initial begin
      quiet_cycles = 0;
      sent_count = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pop on empty, extreme batches, overflowing batch, two pops.
      send_beat(pop_beat());
      send_beat(extreme_sample(1'b1, 1'b1));
      send_beat(extreme_sample(1'b0, 1'b0));
      send_beat(extreme_sample(1'b0, 1'b1));
      for (int i = 0; i < 18; i++) send_beat(extreme_sample(1'b1, i == 17));
      send_beat(pop_beat());
      send_beat(pop_beat());

      // Long receiver hold-off while the sender keeps offering; stores wrap the ring, pops drain it.
      hold_off <= 300;
      for (int i = 0; i < 14; i++) send_beat(random_sample(1'b1));
      for (int i = 0; i < 12; i++) send_beat(pop_beat());

      send_idle_pct = 26;
      recv_idle_pct = 81;
      random_phase(RandomItems / 3);
      send_idle_pct = 81;
      recv_idle_pct = 26;
      random_phase(RandomItems / 3);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(RandomItems / 3);
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d beats, %0d of them closed batches, under three stall mixes",
               sent_count, stored_count);
      if (error_count == 0) begin
         $display("averaging_overwrite_ring_buffer regression: pass");
      end else begin
         $display("averaging_overwrite_ring_buffer regression: fail");
      end
      $finish;
   end

endmodule
